FILE: rtl/sgpr_pkg.sv
// ----------------------------------------------------------------------------
// sgpr_pkg
// Shared types and codes of the scaled glyph pixel renderer.
// ----------------------------------------------------------------------------
package sgpr_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_FIRST_CODE  = 3'd0,
    REG_LAST_CODE   = 3'd1,
    REG_GLYPH_WIDTH = 3'd2,
    REG_CELL_WIDTH  = 3'd3,
    REG_GLYPH_ROWS  = 3'd4,
    REG_TWO_BYTE    = 3'd5,
    REG_SPARE6      = 3'd6,
    REG_SPARE7      = 3'd7
  } reg_e;

  localparam int unsigned PaddrW = 5;
  localparam int unsigned ProdW  = 13;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  font_addr;
    logic [15:0] font_word;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  scale;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [7:0] first_code;
    logic [7:0] last_code;
    logic [4:0] glyph_width;
    logic [4:0] cell_width;
    logic [4:0] glyph_rows;
    logic       two_byte_columns;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        two_byte;
    logic [3:0]  row;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        last;
  } pix_ctl_t;

endpackage

FILE: rtl/scaled_glyph_pixel_renderer.sv
// ----------------------------------------------------------------------------
// scaled_glyph_pixel_renderer
// Renders one character cell of a column-major bitmap font, scaled, as a
// row-major stream of RGB565 pixels.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: font writes, starts and ticks all issue
// back to back. A tick's font word and pixel controls are registered at the
// edge that takes it, and its pixel loads into the output register when free.
// The input side stalls only while a pixel sits in the output register under
// stall with another pixel behind it. FONT_WORDS must be a power of two.
module scaled_glyph_pixel_renderer #(
  parameter int unsigned FONT_WORDS       = 1024,
  parameter int unsigned MAX_CELL_COLUMNS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sgpr_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sgpr_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sgpr_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sgpr_pkg::*;

  localparam int unsigned AddrW = $clog2(FONT_WORDS);

  cfg_t             cfg_q, cfg_d;
  reg_e             reg_idx;
  logic             cfg_wr;
  logic             adv;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [15:0]      rdata;
  pix_ctl_t         pix_ctl;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_FIRST_CODE:  cfg_d.first_code       = pwdata[7:0];
        REG_LAST_CODE:   cfg_d.last_code        = pwdata[7:0];
        REG_GLYPH_WIDTH: cfg_d.glyph_width      = pwdata[4:0];
        REG_CELL_WIDTH:  cfg_d.cell_width       = pwdata[4:0];
        REG_GLYPH_ROWS:  cfg_d.glyph_rows       = pwdata[4:0];
        REG_TWO_BYTE:    cfg_d.two_byte_columns = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST_CODE:  prdata = {24'd0, cfg_q.first_code};
      REG_LAST_CODE:   prdata = {24'd0, cfg_q.last_code};
      REG_GLYPH_WIDTH: prdata = {27'd0, cfg_q.glyph_width};
      REG_CELL_WIDTH:  prdata = {27'd0, cfg_q.cell_width};
      REG_GLYPH_ROWS:  prdata = {27'd0, cfg_q.glyph_rows};
      REG_TWO_BYTE:    prdata = {31'd0, cfg_q.two_byte_columns};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_code       <= 8'd32;
      cfg_q.last_code        <= 8'd127;
      cfg_q.glyph_width      <= 5'd5;
      cfg_q.cell_width       <= 5'd6;
      cfg_q.glyph_rows       <= 5'd7;
      cfg_q.two_byte_columns <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sgpr_walker #(
    .AddrW    (AddrW),
    .MaxCells (MAX_CELL_COLUMNS)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .adv_i      (adv),
    .we_o       (we),
    .waddr_o    (waddr),
    .re_o       (re),
    .raddr_o    (raddr),
    .pix_ctl_o  (pix_ctl)
  );

  sgpr_font_ram #(
    .Words (FONT_WORDS),
    .AddrW (AddrW)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.font_word),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sgpr_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_ctl_i   (pix_ctl),
    .rdata_i     (rdata),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/sgpr_font_ram.sv
// ----------------------------------------------------------------------------
// sgpr_font_ram
// Font word memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgpr_font_ram #(
  parameter int unsigned Words = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem [Words];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sgpr_walker.sv
// ----------------------------------------------------------------------------
// sgpr_walker
// Takes input transactions, holds the character state, walks the scaled
// cell and issues a font read whenever its input side is not stalled.
// ----------------------------------------------------------------------------
module sgpr_walker #(
  parameter int unsigned AddrW     = 10,
  parameter int unsigned MaxCells  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sgpr_pkg::in_item_t  in_item_i,
  input  sgpr_pkg::cfg_t      cfg_i,
  input  logic                adv_i,
  output logic                we_o,
  output logic [AddrW-1:0]    waddr_o,
  output logic                re_o,
  output logic [AddrW-1:0]    raddr_o,
  output sgpr_pkg::pix_ctl_t  pix_ctl_o
);
  import sgpr_pkg::*;

  localparam logic [4:0] MaxCellsW = 5'(MaxCells);

  logic [AddrW-1:0] base_q, base_d;
  logic             in_range_q, in_range_d;
  logic [15:0]      fg_q, fg_d, bg_q, bg_d;
  logic [7:0]       scale_q, scale_d;
  logic [3:0]       row_q, row_d;
  logic [7:0]       row_rep_q, row_rep_d;
  logic [3:0]       col_q, col_d;
  logic [7:0]       col_rep_q, col_rep_d;
  logic             drawing_q, drawing_d;
  pix_ctl_t         pix_ctl_q, pix_ctl_d;

  logic                   en0, acc, tick;
  logic [4:0]             cells, rows;
  logic                   code_ok;
  logic [7:0]             code_off;
  logic [ProdW-1:0]       prod;
  logic [AddrW+ProdW-1:0] prod_ext;
  logic [AddrW+9:0]       waddr_ext;
  logic [8:0]             col_rep_n, row_rep_n;
  logic [4:0]             col_n, row_n;
  logic                   last;

  assign en0        = !pix_ctl_q.valid || adv_i;
  assign in_stall_o = !en0;
  assign acc        = in_valid_i && en0;
  assign tick       = acc && (in_item_i.func == FUNC_TICK) && drawing_q;

  assign cells = (cfg_i.cell_width == 5'd0) ? 5'd1 :
                 (cfg_i.cell_width > MaxCellsW) ? MaxCellsW : cfg_i.cell_width;
  assign rows  = (cfg_i.glyph_rows == 5'd0) ? 5'd1 :
                 (cfg_i.glyph_rows > 5'd16) ? 5'd16 : cfg_i.glyph_rows;

  assign code_ok  = (in_item_i.char_code >= cfg_i.first_code) &&
                    (in_item_i.char_code <= cfg_i.last_code);
  assign code_off = in_item_i.char_code - cfg_i.first_code;
  assign prod     = ProdW'(code_off * cfg_i.glyph_width);
  assign prod_ext = {{AddrW{1'b0}}, prod};

  assign waddr_ext = {{AddrW{1'b0}}, in_item_i.font_addr};
  assign we_o      = acc && (in_item_i.func == FUNC_WRITE);
  assign waddr_o   = waddr_ext[AddrW-1:0];
  assign re_o      = en0;
  assign raddr_o   = base_q + AddrW'(col_q);

  assign col_rep_n = {1'b0, col_rep_q} + 9'd1;
  assign row_rep_n = {1'b0, row_rep_q} + 9'd1;
  assign col_n     = {1'b0, col_q} + 5'd1;
  assign row_n     = {1'b0, row_q} + 5'd1;

  always_comb begin
    base_d     = base_q;
    in_range_d = in_range_q;
    fg_d       = fg_q;
    bg_d       = bg_q;
    scale_d    = scale_q;
    row_d      = row_q;
    row_rep_d  = row_rep_q;
    col_d      = col_q;
    col_rep_d  = col_rep_q;
    drawing_d  = drawing_q;
    last       = 1'b0;
    if (acc && (in_item_i.func == FUNC_START)) begin
      in_range_d = code_ok;
      base_d     = code_ok ? prod_ext[AddrW-1:0] : '0;
      fg_d       = in_item_i.fg_color;
      bg_d       = in_item_i.bg_color;
      scale_d    = (in_item_i.scale == 8'd0) ? 8'd1 : in_item_i.scale;
      row_d      = '0;
      row_rep_d  = '0;
      col_d      = '0;
      col_rep_d  = '0;
      drawing_d  = 1'b1;
    end else if (tick) begin
      col_rep_d = col_rep_n[7:0];
      if (col_rep_n >= {1'b0, scale_q}) begin
        col_rep_d = '0;
        col_d     = col_n[3:0];
        if (col_n >= cells) begin
          col_d     = '0;
          row_rep_d = row_rep_n[7:0];
          if (row_rep_n >= {1'b0, scale_q}) begin
            row_rep_d = '0;
            row_d     = row_n[3:0];
            if (row_n >= rows) begin
              row_d     = '0;
              last      = 1'b1;
              drawing_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    pix_ctl_d          = pix_ctl_q;
    if (en0) begin
      pix_ctl_d.valid    = tick;
      pix_ctl_d.hit      = in_range_q && ({1'b0, col_q} < cfg_i.glyph_width);
      pix_ctl_d.two_byte = cfg_i.two_byte_columns;
      pix_ctl_d.row      = row_q;
      pix_ctl_d.fg       = fg_q;
      pix_ctl_d.bg       = bg_q;
      pix_ctl_d.last     = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      in_range_q <= 1'b0;
      fg_q       <= '0;
      bg_q       <= '0;
      scale_q    <= 8'd1;
      row_q      <= '0;
      row_rep_q  <= '0;
      col_q      <= '0;
      col_rep_q  <= '0;
      drawing_q  <= 1'b0;
      pix_ctl_q  <= '0;
    end else begin
      base_q     <= base_d;
      in_range_q <= in_range_d;
      fg_q       <= fg_d;
      bg_q       <= bg_d;
      scale_q    <= scale_d;
      row_q      <= row_d;
      row_rep_q  <= row_rep_d;
      col_q      <= col_d;
      col_rep_q  <= col_rep_d;
      drawing_q  <= drawing_d;
      pix_ctl_q  <= pix_ctl_d;
    end
  end

  assign pix_ctl_o = pix_ctl_q;

endmodule

FILE: rtl/sgpr_shade.sv
// ----------------------------------------------------------------------------
// sgpr_shade
// Selects the glyph bit from the font word, picks the color and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module sgpr_shade (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sgpr_pkg::pix_ctl_t  pix_ctl_i,
  input  logic [15:0]         rdata_i,
  output logic                adv_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sgpr_pkg::out_item_t out_item_o
);
  import sgpr_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      bit_set, px_set;

  assign adv_o   = !out_valid_q || !out_stall_i;
  assign bit_set = rdata_i[pix_ctl_i.row];
  assign px_set  = pix_ctl_i.hit && bit_set && (pix_ctl_i.two_byte || !pix_ctl_i.row[3]);

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (adv_o) begin
      out_valid_d = pix_ctl_i.valid;
      if (pix_ctl_i.valid) begin
        out_item_d.pixel_color = px_set ? pix_ctl_i.fg : pix_ctl_i.bg;
        out_item_d.last_pixel  = pix_ctl_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: rtl/sgpr_checker.sv
// ----------------------------------------------------------------------------
// sgpr_checker
// Port-level checks of the renderer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sgpr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sgpr_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sgpr_pkg::out_item_t out_item_o
);
  import sgpr_pkg::*;

  logic tick_acc;

  assign tick_acc = in_valid_i && !in_stall_o && (in_item_i.func == FUNC_TICK);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(tick_acc) |=> !out_valid_o)
    else $error("result without a tick transaction");

endmodule

bind scaled_glyph_pixel_renderer sgpr_checker u_sgpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
